@@ rtl/n2a_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2a_pkg
// Shared widths, color constants and bundle types of the NV21 to ARGB
// converter.
// ----------------------------------------------------------------------------
package n2a_pkg;

  localparam int POS_W  = 21;  // byte position within a frame buffer
  localparam int IDX_W  = 20;  // pixel index on the output
  localparam int LIDX_W = 24;  // internal pixel index, wide enough for any store
  localparam int DIM_W  = 11;  // width and height registers
  localparam int HALF_W = 10;  // chroma columns per row
  localparam int FS_W   = 22;  // luma plane size
  localparam int TOT_W  = 23;  // whole frame buffer size
  localparam int DIV_W  = 20;  // chroma pair number
  localparam int CW     = 22;  // signed color arithmetic

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd480;

  localparam logic signed [CW-1:0] C_Y   = 22'sd1192;
  localparam logic signed [CW-1:0] C_RV  = 22'sd1634;
  localparam logic signed [CW-1:0] C_GV  = 22'sd833;
  localparam logic signed [CW-1:0] C_GU  = 22'sd400;
  localparam logic signed [CW-1:0] C_BU  = 22'sd2066;
  localparam logic signed [CW-1:0] CHAN_MAX = 22'sd262143;
  localparam logic [7:0] Y_OFS = 8'd16;
  localparam logic signed [8:0] C_OFS = 9'sd128;
  localparam logic [7:0] ALPHA = 8'hff;

  typedef struct packed {
    logic [DIM_W-1:0]  w;
    logic [HALF_W-1:0] half;
    logic [FS_W-1:0]   fsize;
    logic [TOT_W-1:0]  total;
    logic              busy;
    logic              load;
    logic [HALF_W-1:0] ccol;
    logic [LIDX_W-1:0] row_base;
  } geom_t;

  typedef struct packed {
    logic [LIDX_W-1:0] base;
    logic [7:0]        v;
    logic [7:0]        u;
    logic              last;
  } job_t;

  typedef struct packed {
    logic busy;
    logic free;
  } job_stat_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [31:0]      argb;
    logic             last;
    logic             eof;
  } pix_t;

  // Clamp to 18 bits and keep the top eight.
  function automatic logic [7:0] chan8(input logic signed [CW-1:0] x);
    logic [7:0] r;
    if (x < 0) begin
      r = 8'd0;
    end else if (x > CHAN_MAX) begin
      r = 8'hff;
    end else begin
      r = x[17:10];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/n2a_luma_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2a_luma_mem
// Luma plane store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module n2a_luma_mem #(
  parameter int DEPTH = 1048576,
  parameter int AW    = 20
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/n2a_geom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2a_geom
// Register port and frame geometry: effective width and height, plane sizes,
// and the chroma column and row base that belong to the current position.
// ----------------------------------------------------------------------------
module n2a_geom
  import n2a_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  input  wire logic [POS_W-1:0] pos_i,
  output geom_t                 geom_o
);

  localparam logic [DIM_W-1:0] LIM_W = (MAX_WIDTH > 2047) ? 11'h7ff : DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] LIM_H = (MAX_HEIGHT > 2047) ? 11'h7ff : DIM_W'(MAX_HEIGHT);
  localparam int CNT_W = $clog2(DIV_W);
  localparam int PRD_W = DIV_W + DIM_W;

  typedef enum logic [2:0] {
    RC_IDLE, RC_DIM, RC_MUL, RC_TOT, RC_SET, RC_DIV, RC_ROW
  } rc_state_e;

  rc_state_e         state_q;
  logic [DIM_W-1:0]  cfg_w_q, cfg_h_q;
  logic [DIM_W-1:0]  w_q, h_q;
  logic [HALF_W-1:0] half_q;
  logic [FS_W-1:0]   fsize_q;
  logic [TOT_W-1:0]  total_q;
  logic [DIV_W-1:0]  dvd_q;
  logic [HALF_W-1:0] rem_q, ccol_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [LIDX_W-1:0] row_base_q;
  logic              load_q;
  logic              wr;
  logic [HALF_W:0]   trial;
  logic              qbit;
  logic [TOT_W-1:0]  pos_ext, k;
  logic [PRD_W-1:0]  prod;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                input logic [DIM_W-1:0] lim);
    logic [DIM_W-1:0] r;
    r = (v > lim) ? lim : v;
    r[0] = 1'b0;
    if (r < 2) begin
      r = 11'd2;
    end
    return r;
  endfunction

  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, cfg_w_q};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, cfg_h_q};
      default:    prdata = '0;
    endcase
  end

  // One step of the restoring division of the pair number by the row's pairs.
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign qbit  = (trial >= {1'b0, half_q});
  assign pos_ext = TOT_W'(pos_i);
  assign k       = pos_ext - TOT_W'(fsize_q);
  assign prod    = PRD_W'(dvd_q) * PRD_W'(w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= RC_DIM;
      cfg_w_q    <= RST_WIDTH;
      cfg_h_q    <= RST_HEIGHT;
      w_q        <= '0;
      h_q        <= '0;
      half_q     <= '0;
      fsize_q    <= '0;
      total_q    <= '0;
      dvd_q      <= '0;
      rem_q      <= '0;
      ccol_q     <= '0;
      cnt_q      <= '0;
      row_base_q <= '0;
      load_q     <= 1'b0;
    end else begin
      load_q <= 1'b0;
      if (wr) begin
        unique case (paddr[2])
          REG_WIDTH:  cfg_w_q <= pwdata[DIM_W-1:0];
          REG_HEIGHT: cfg_h_q <= pwdata[DIM_W-1:0];
          default:    cfg_w_q <= cfg_w_q;
        endcase
        state_q <= RC_DIM;
      end else begin
        unique case (state_q)
          RC_IDLE: state_q <= RC_IDLE;
          RC_DIM: begin
            w_q     <= eff_dim(cfg_w_q, LIM_W);
            h_q     <= eff_dim(cfg_h_q, LIM_H);
            state_q <= RC_MUL;
          end
          RC_MUL: begin
            half_q  <= w_q[DIM_W-1:1];
            fsize_q <= FS_W'(w_q) * FS_W'(h_q);
            state_q <= RC_TOT;
          end
          RC_TOT: begin
            total_q <= TOT_W'(fsize_q) + TOT_W'(fsize_q[FS_W-1:1]);
            state_q <= RC_SET;
          end
          RC_SET: begin
            // Only a position inside the chroma area needs its pair located.
            if (pos_ext >= TOT_W'(fsize_q) && pos_ext < total_q) begin
              dvd_q   <= k[DIV_W:1];
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= RC_DIV;
            end else begin
              state_q <= RC_IDLE;
            end
          end
          RC_DIV: begin
            rem_q <= qbit ? HALF_W'(trial - {1'b0, half_q}) : trial[HALF_W-1:0];
            dvd_q <= {dvd_q[DIV_W-2:0], qbit};
            cnt_q <= cnt_q + 1'b1;
            if (cnt_q == CNT_W'(DIV_W - 1)) begin
              state_q <= RC_ROW;
            end
          end
          RC_ROW: begin
            ccol_q     <= rem_q;
            row_base_q <= {prod[LIDX_W-2:0], 1'b0};
            load_q     <= 1'b1;
            state_q    <= RC_IDLE;
          end
          default: state_q <= RC_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    geom_o.w        = w_q;
    geom_o.half     = half_q;
    geom_o.fsize    = fsize_q;
    geom_o.total    = total_q;
    geom_o.busy     = (state_q != RC_IDLE) | load_q;
    geom_o.load     = load_q;
    geom_o.ccol     = ccol_q;
    geom_o.row_base = row_base_q;
  end

endmodule
`default_nettype wire

@@ rtl/n2a_pix_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// n2a_pix_pipe
// Pixel path: walks the four luma reads of a chroma pair, converts each
// pixel to ARGB and queues the results in front of the output channel.
// ----------------------------------------------------------------------------
module n2a_pix_pipe
  import n2a_pkg::*;
#(
  parameter int STORE_DEPTH = 1048576
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              job_load_i,
  input  wire job_t              job_i,
  input  wire logic [DIM_W-1:0]  w_i,
  output job_stat_t              stat_o,
  output logic                   rd_en_o,
  output logic      [LIDX_W-1:0] rd_idx_o,
  input  wire logic [7:0]        rd_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [IDX_W-1:0]  pixel_index_o,
  output logic      [31:0]       argb_o,
  output logic                   last_of_run_o,
  output logic                   end_of_frame_o
);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  job_t                    job_q;
  logic                    busy_q;
  logic [1:0]              cnt_q;
  logic                    issue, in_range;
  logic [LIDX_W-1:0]       idx;
  logic signed [8:0]       v_s, u_s;
  logic signed [CW-1:0]    rv, gv, bu;

  logic                    s1_valid_q, s1_inr_q, s1_last_q, s1_eof_q;
  logic [IDX_W-1:0]        s1_idx_q;
  logic signed [CW-1:0]    s1_rv_q, s1_gv_q, s1_bu_q;

  logic [7:0]              y8;
  logic signed [CW-1:0]    y_term;
  pix_t                    pix;

  pix_t                    fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]        count_q;
  logic                    pop;

  // A read goes out only when the queue has room for it and the one in flight.
  assign issue    = busy_q & ((count_q + CNT_W'(s1_valid_q)) < CNT_W'(FIFO_DEPTH));
  assign idx      = job_q.base + (cnt_q[1] ? LIDX_W'(w_i) : '0) + LIDX_W'(cnt_q[0]);
  assign in_range = (32'(idx) < STORE_DEPTH);
  assign rd_en_o  = issue & in_range;
  assign rd_idx_o = idx;

  assign stat_o.busy = busy_q;
  assign stat_o.free = ~busy_q | (issue & (cnt_q == 2'd3));

  assign v_s = $signed({1'b0, job_q.v}) - C_OFS;
  assign u_s = $signed({1'b0, job_q.u}) - C_OFS;
  assign rv  = C_RV * CW'(v_s);
  assign gv  = -(C_GV * CW'(v_s)) - (C_GU * CW'(u_s));
  assign bu  = C_BU * CW'(u_s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (job_load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (issue) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == 2'd3) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_load_i) begin
      job_q <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_idx_q  <= idx[IDX_W-1:0];
      s1_inr_q  <= in_range;
      s1_last_q <= (cnt_q == 2'd3);
      s1_eof_q  <= (cnt_q == 2'd3) & job_q.last;
      s1_rv_q   <= rv;
      s1_gv_q   <= gv;
      s1_bu_q   <= bu;
    end
  end

  // Luma outside the store reads as zero, which floors to zero as well.
  assign y8     = (s1_inr_q && rd_data_i >= Y_OFS) ? (rd_data_i - Y_OFS) : 8'd0;
  assign y_term = $signed(CW'(y8)) * C_Y;

  always_comb begin
    pix.idx  = s1_idx_q;
    pix.argb = {ALPHA, chan8(y_term + s1_rv_q), chan8(y_term + s1_gv_q),
                chan8(y_term + s1_bu_q)};
    pix.last = s1_last_q;
    pix.eof  = s1_eof_q;
  end

  assign pop = (count_q != '0) & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (s1_valid_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(s1_valid_q) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fifo_q[wr_ptr_q] <= pix;
    end
  end

  assign out_valid_o    = (count_q != '0);
  assign pixel_index_o  = fifo_q[rd_ptr_q].idx;
  assign argb_o         = fifo_q[rd_ptr_q].argb;
  assign last_of_run_o  = fifo_q[rd_ptr_q].last;
  assign end_of_frame_o = fifo_q[rd_ptr_q].eof;

endmodule
`default_nettype wire

@@ rtl/nv21_to_argb_converter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nv21_to_argb_converter
// NV21 frame bytes in, ARGB8888 pixels with raster index out.
// ----------------------------------------------------------------------------
// The input channel takes one frame buffer byte per item, luma plane first,
// then V,U pairs; start_of_frame_i marks byte zero of a new frame. Luma bytes
// go into the luma store and give no output. Each U byte gives four output
// items, the 2x2 pixel block of that chroma pair, top row first.
// Luma bytes and V bytes are taken one per cycle, but luma bytes wait while a
// walk is in progress. A U byte starts a walk of four reads over the single
// read port of the luma store; the next V byte is taken during the walk and
// the next U byte as the walk issues its last read. The first pixel of a pair
// passes the job register, the read registers and the output queue; the others
// follow one per cycle while the queue has room. When the receiver stalls, a
// four-item queue fills, the walk pauses and then U and luma bytes are stalled.
// After reset, and after each register write, the input is stalled while the
// frame geometry is worked out again. The luma store is not cleared.
// ----------------------------------------------------------------------------
module nv21_to_argb_converter
  import n2a_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              start_of_frame_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [IDX_W-1:0]  pixel_index_o,
  output logic      [31:0]       argb_o,
  output logic                   last_of_run_o,
  output logic                   end_of_frame_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(STORE_DEPTH);

  geom_t             geom;
  job_stat_t         jstat;
  job_t              job;
  logic [POS_W-1:0]  pos_q, p_eff;
  logic [7:0]        held_v_q;
  logic [HALF_W-1:0] ccol_q;
  logic [LIDX_W-1:0] row_base_q;
  logic [TOT_W-1:0]  p_inc;
  logic              is_luma, is_u, is_v, in_acc, job_load, luma_we;
  logic              rd_en;
  logic [LIDX_W-1:0] rd_idx;
  logic [7:0]        rd_data;

  n2a_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pos_i   (pos_q),
    .geom_o  (geom)
  );

  // A stored position past the end of the frame counts as byte zero.
  assign p_eff   = (start_of_frame_i || TOT_W'(pos_q) >= geom.total) ? '0 : pos_q;
  assign is_luma = (FS_W'(p_eff) < geom.fsize);
  assign is_v    = ~is_luma & ~p_eff[0];
  assign is_u    = ~is_luma & p_eff[0];
  assign p_inc   = TOT_W'(p_eff) + 1'b1;

  always_comb begin
    if (geom.busy) begin
      in_stall_o = 1'b1;
    end else if (is_u) begin
      in_stall_o = ~jstat.free;
    end else if (is_luma) begin
      in_stall_o = jstat.busy;
    end else begin
      in_stall_o = 1'b0;
    end
  end

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign job_load = in_acc & is_u;
  assign luma_we  = in_acc & is_luma & (32'(p_eff) < STORE_DEPTH);

  always_comb begin
    job.base = row_base_q + LIDX_W'({ccol_q, 1'b0});
    job.v    = held_v_q;
    job.u    = data_byte_i;
    job.last = (p_inc == geom.total);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      held_v_q   <= '0;
      ccol_q     <= '0;
      row_base_q <= '0;
    end else if (geom.load) begin
      ccol_q     <= geom.ccol;
      row_base_q <= geom.row_base;
    end else if (in_acc) begin
      pos_q <= (p_inc >= geom.total) ? '0 : p_inc[POS_W-1:0];
      if (is_v) begin
        held_v_q <= data_byte_i;
      end
      // The last luma byte rewinds the chroma walk to the first pair.
      if (is_luma && FS_W'(p_eff) == geom.fsize - 1'b1) begin
        ccol_q     <= '0;
        row_base_q <= '0;
      end
      if (is_u) begin
        if (ccol_q + 1'b1 == geom.half) begin
          ccol_q     <= '0;
          row_base_q <= row_base_q + LIDX_W'({geom.w, 1'b0});
        end else begin
          ccol_q <= ccol_q + 1'b1;
        end
      end
    end
  end

  n2a_luma_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_luma_mem (
    .clk_i   (clk_i),
    .we_i    (luma_we),
    .waddr_i (AW'(p_eff)),
    .wdata_i (data_byte_i),
    .re_i    (rd_en),
    .raddr_i (AW'(rd_idx)),
    .rdata_o (rd_data)
  );

  n2a_pix_pipe #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_pix_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_load_i     (job_load),
    .job_i          (job),
    .w_i            (geom.w),
    .stat_o         (jstat),
    .rd_en_o        (rd_en),
    .rd_idx_o       (rd_idx),
    .rd_data_i      (rd_data),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pixel_index_o  (pixel_index_o),
    .argb_o         (argb_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
`default_nettype wire
